### hw/rtl/tlvd_pkg.sv
`default_nettype none

package tlvd_pkg;

   localparam int unsigned BUF_BYTES = 512;
   localparam int unsigned CountWidth = 17;
   localparam int unsigned LenWidth = 16;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_DROP    = 2'd2;

   localparam logic [CountWidth-1:0] BUF_LIMIT = CountWidth'(BUF_BYTES);

   typedef enum logic [3:0] {
      PH_TYPE    = 4'b0001,
      PH_LEN_LO  = 4'b0010,
      PH_LEN_HI  = 4'b0100,
      PH_PAYLOAD = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_end;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_type;
      logic [7:0] data_byte;
      logic [1:0] result_kind;
      logic       frame_last;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/tlv_frame_deframer.sv
`default_nettype none

// channel  valid      stall      beat
// -------  ---------  ---------  ----------------------------------------------
// req      req_valid  req_stall  req_data: rx_byte, chunk_end
// rsp      rsp_valid  rsp_stall  rsp_data: frame_type, data_byte, result_kind,
//                                frame_last
//
// one beat per cycle while req_stall is low: a byte is parsed in the cycle it
// is accepted, and its result, if any, is registered in the output register
// or, while a result waits there, in the skid register behind it, which lets
// a byte be taken; req_stall is raised, from a flop, only once the skid is full.
// reset is synchronous and active high and returns the parser to the type
// byte with no discard pending and both result registers empty.
// bytes that give no result are taken even while rsp is stalled, as long as
// the skid has room.

module tlv_frame_deframer
   import tlvd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,

   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,

   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   phase_type             phase_ff, phase_in;
   logic [7:0]            held_type_ff, held_type_in;
   logic [7:0]            length_low_ff, length_low_in;
   logic [LenWidth-1:0]   remaining_ff, remaining_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  discard_ff, discard_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   rsp_type               skid_data_ff, skid_data_in;

   logic                  accept;
   logic                  take;
   logic                  emit;
   logic                  done;
   logic                  drop;
   logic [CountWidth-1:0] count_inc;
   logic [LenWidth-1:0]   remaining_dec;
   logic [LenWidth-1:0]   length_full;
   rsp_type               result;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign count_inc     = count_ff + CountWidth'(1);
   assign remaining_dec = remaining_ff - LenWidth'(1);
   assign length_full   = {req_data.rx_byte, length_low_ff};

   // parser
   always_comb begin
      phase_in     = phase_ff;
      held_type_in = held_type_ff;
      length_low_in = length_low_ff;
      remaining_in = remaining_ff;
      count_in     = count_ff;
      discard_in   = discard_ff;
      emit         = 1'b0;
      done         = 1'b0;
      drop         = 1'b0;
      result.frame_type  = held_type_ff;
      result.data_byte   = 8'd0;
      result.result_kind = KIND_PAYLOAD;
      result.frame_last  = 1'b0;

      if (discard_ff) begin
         if (req_data.chunk_end) begin
            discard_in   = 1'b0;
            phase_in     = PH_TYPE;
            count_in     = '0;
            remaining_in = '0;
         end
      end else begin
         count_in = count_inc;
         unique case (phase_ff)
            PH_TYPE: begin
               held_type_in = req_data.rx_byte;
               phase_in     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_low_in = req_data.rx_byte;
               phase_in      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               remaining_in = length_full;
               if (length_full == '0) begin
                  emit               = 1'b1;
                  done               = 1'b1;
                  result.result_kind = KIND_EMPTY;
                  result.frame_last  = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               remaining_in      = remaining_dec;
               emit              = 1'b1;
               done              = (remaining_dec == '0);
               result.data_byte  = req_data.rx_byte;
               result.frame_last = (remaining_dec == '0);
            end
            default: begin
               phase_in = PH_TYPE;
            end
         endcase
         result.frame_type = held_type_in;

         drop = (count_inc > BUF_LIMIT);
         if (drop) begin
            emit               = 1'b1;
            result.data_byte   = 8'd0;
            result.result_kind = KIND_DROP;
            result.frame_last  = 1'b1;
            phase_in           = PH_TYPE;
            remaining_in       = '0;
            count_in           = '0;
            discard_in         = !req_data.chunk_end;
         end else if (done) begin
            phase_in = PH_TYPE;
            count_in = '0;
         end
      end
   end

   // output register and skid
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept && emit;
            rsp_data_in  = result;
         end
      end else if (accept && emit) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TYPE;
         held_type_ff  <= 8'd0;
         length_low_ff <= 8'd0;
         remaining_ff  <= '0;
         count_ff      <= '0;
         discard_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            held_type_ff  <= held_type_in;
            length_low_ff <= length_low_in;
            remaining_ff  <= remaining_in;
            count_ff      <= count_in;
            discard_ff    <= discard_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a beat while the output register is empty");

   a_count_within_buffer: assert property (@(posedge clock) disable iff (reset)
      count_ff <= BUF_LIMIT)
      else $error("frame byte count passed the buffer size without a drop");

   a_payload_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remaining_ff != '0))
      else $error("payload phase with nothing left to take");

   a_discard_restarts: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (phase_ff == PH_TYPE && count_ff == '0))
      else $error("discard pending with a frame still in progress");

   a_drop_and_empty_are_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.result_kind != KIND_PAYLOAD)
         |-> (rsp_data_ff.frame_last && rsp_data_ff.data_byte == 8'd0))
      else $error("empty or dropped result not marked last");

endmodule

`default_nettype wire

### bench/tlv_frame_deframer_tb.sv
`default_nettype none

module tlv_frame_deframer_tb;
   import tlvd_pkg::*;

   typedef struct packed {
      req_type beat;
      logic    pinned;
      rsp_type want;
   } script_row_type;

   localparam rsp_type NO_RSP = '0;
   localparam int SCRIPT_LEN = 18;

   // directed bytes; rows with pinned set carry their result typed in
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      {8'hFF, 1'b0, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b0, NO_RSP},
      {8'h00, 1'b1, 1'b1, {8'hFF, 8'h00, KIND_EMPTY, 1'b1}},
      {8'h00, 1'b0, 1'b0, NO_RSP},
      {8'h02, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b0, NO_RSP},
      {8'hFF, 1'b0, 1'b1, {8'h00, 8'hFF, KIND_PAYLOAD, 1'b0}},
      {8'h00, 1'b1, 1'b1, {8'h00, 8'h00, KIND_PAYLOAD, 1'b1}},
      {8'hA5, 1'b1, 1'b0, NO_RSP},
      {8'h01, 1'b1, 1'b0, NO_RSP},
      {8'h00, 1'b1, 1'b0, NO_RSP},
      {8'h5A, 1'b1, 1'b1, {8'hA5, 8'h5A, KIND_PAYLOAD, 1'b1}},
      {8'h3C, 1'b0, 1'b0, NO_RSP},
      {8'h03, 1'b0, 1'b0, NO_RSP},
      {8'h00, 1'b0, 1'b0, NO_RSP},
      {8'h81, 1'b1, 1'b0, NO_RSP},
      {8'h7E, 1'b0, 1'b0, NO_RSP},
      {8'h18, 1'b0, 1'b0, NO_RSP}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      send_idle_pct = 0;
   int      rcv_idle_pct = 0;
   int      beats_sent = 0;
   int      mismatches = 0;
   rsp_type due_results [$];

   // parser state of the predictor
   phase_type                 parse_ph = PH_TYPE;
   logic [7:0]                held_type = '0;
   logic [7:0]                len_lo = '0;
   logic [LenWidth-1:0]       remaining = '0;
   logic [CountWidth-1:0]     byte_count = '0;
   logic                      discarding = 1'b0;

   tlv_frame_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit deframe_byte(input req_type beat, output rsp_type res);
      bit         emit;
      bit         done;
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
      emit = 1'b0;
      done = 1'b0;
      data = '0;
      kind = KIND_PAYLOAD;
      last = 1'b0;
      res = '0;
      if (discarding) begin
         if (beat.chunk_end) begin
            discarding = 1'b0;
            parse_ph = PH_TYPE;
            byte_count = '0;
            remaining = '0;
         end
         return 1'b0;
      end
      byte_count = byte_count + 1'b1;
      case (parse_ph)
         PH_TYPE: begin
            held_type = beat.rx_byte;
            parse_ph = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_lo = beat.rx_byte;
            parse_ph = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            remaining = {beat.rx_byte, len_lo};
            if (remaining == '0) begin
               emit = 1'b1;
               kind = KIND_EMPTY;
               last = 1'b1;
               done = 1'b1;
            end else begin
               parse_ph = PH_PAYLOAD;
            end
         end
         default: begin
            remaining = remaining - 1'b1;
            emit = 1'b1;
            data = beat.rx_byte;
            last = (remaining == '0);
            done = last;
         end
      endcase
      if (byte_count > BUF_LIMIT) begin
         res = {held_type, 8'h00, KIND_DROP, 1'b1};
         parse_ph = PH_TYPE;
         remaining = '0;
         byte_count = '0;
         discarding = !beat.chunk_end;
         return 1'b1;
      end
      if (done) begin
         parse_ph = PH_TYPE;
         byte_count = '0;
      end
      if (emit) begin
         res = {held_type, data, kind, last};
      end
      return emit;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatches < 40) begin
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      end
      mismatches++;
   endtask

   // one beat: random gap, then hold until taken
   task automatic send_beat(input logic [7:0] rx, input logic ce, input bit pinned,
                            input rsp_type want);
      req_type beat;
      rsp_type res;
      beat = {rx, ce};
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (deframe_byte(beat, res)) begin
         due_results.push_back(pinned ? want : res);
      end
   endtask

   task automatic send_byte(input logic [7:0] rx, input logic ce);
      send_beat(rx, ce, 1'b0, NO_RSP);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_frame();
      logic [15:0] len;
      int          pick;
      int          i;
      pick = $urandom_range(0, 15);
      if (pick < 2) len = '0;
      else if (pick < 12) len = 16'($urandom_range(1, 8));
      else len = 16'($urandom_range(9, 40));
      send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      send_byte(len[7:0], $urandom_range(0, 3) == 0);
      send_byte(len[15:8], $urandom_range(0, 3) == 0);
      for (i = 0; i < int'(len); i++) begin
         send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   // header plus payload up to the byte that passes the buffer size, then, if needed, bytes to a chunk end
   task automatic send_oversized(input logic [15:0] len, input bit drop_on_end);
      int i;
      send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      send_byte(len[7:0], $urandom_range(0, 3) == 0);
      send_byte(len[15:8], $urandom_range(0, 3) == 0);
      for (i = 3; i < int'(BUF_BYTES); i++) begin
         send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
      send_byte(8'($urandom), drop_on_end);
      if (!drop_on_end) begin
         for (i = $urandom_range(0, 6); i > 0; i--) begin
            send_byte(8'($urandom), 1'b0);
         end
         send_byte(8'($urandom), 1'b1);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            flag_mismatch("unexpected result", 32'(rsp_data), 32'h0);
         end else begin
            want = due_results.pop_front();
            if (rsp_data.frame_type !== want.frame_type)
               flag_mismatch("frame_type", 32'(rsp_data.frame_type), 32'(want.frame_type));
            if (rsp_data.data_byte !== want.data_byte)
               flag_mismatch("data_byte", 32'(rsp_data.data_byte), 32'(want.data_byte));
            if (rsp_data.result_kind !== want.result_kind)
               flag_mismatch("result_kind", 32'(rsp_data.result_kind),
                             32'(want.result_kind));
            if (rsp_data.frame_last !== want.frame_last)
               flag_mismatch("frame_last", 32'(rsp_data.frame_last), 32'(want.frame_last));
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
   end

   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int ph;
      int start;
      int r;
      send_idle_pct = 17;
      rcv_idle_pct = 67;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (r = 0; r < SCRIPT_LEN; r++) begin
         send_beat(SCRIPT[r].beat.rx_byte, SCRIPT[r].beat.chunk_end, SCRIPT[r].pinned,
                   SCRIPT[r].want);
      end
      wait_drained();
      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 17;
               rcv_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               rcv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         start = beats_sent;
         while (beats_sent - start < 60) begin
            send_frame();
            if ($urandom_range(0, 39) == 0) wait_drained();
         end
         // drop lands on the last payload byte, then discard to the chunk end
         if (ph == 1) begin
            send_oversized(16'(BUF_BYTES - 2), 1'b0);
         end
         start = beats_sent;
         while (beats_sent - start < 60) begin
            send_frame();
         end
         wait_drained();
      end
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/tlvd_pkg.sv
hw/rtl/tlv_frame_deframer.sv
bench/tlv_frame_deframer_tb.sv
